// ===== rtl/core/kdclp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdclp_pkg
// Shared types and constants for the key debounce and click detector.
// ----------------------------------------------------------------------------
package kdclp_pkg;

  // Widths of the fixed ports.
  localparam int KEY_PORT_W  = 8;
  localparam int CFG_TICK_W  = 16;
  localparam int CLICK_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Defaults for the module parameters.
  localparam int NUM_KEYS_DEF   = 8;
  localparam int TICK_CNT_W_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CLICKS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE      = 3'd5;

  // Configuration reset values.
  localparam logic [CFG_TICK_W-1:0] DEBOUNCE_RESET   = 16'd2;
  localparam logic [CFG_TICK_W-1:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [CFG_TICK_W-1:0] CLICK_GAP_RESET  = 16'd30;
  localparam logic [CLICK_W-1:0]    MAX_CLICKS_RESET = 3'd2;

  // Saturation value of the click counter.
  localparam logic [CLICK_W-1:0] CLICK_SAT = 3'd7;

  // Configuration seen by every key.
  typedef struct packed {
    logic [CFG_TICK_W-1:0] debounce_ticks;
    logic [CFG_TICK_W-1:0] long_press_ticks;
    logic [CFG_TICK_W-1:0] click_gap_ticks;
    logic [CLICK_W-1:0]    max_clicks;
    logic                  active_low;
    logic                  long_enable;
  } cfg_t;

  // Per-key pulses for one tick, plus the key's busy flag.
  typedef struct packed {
    logic press;
    logic release_ev;
    logic short_click;
    logic dbl_click;
    logic long_press;
    logic long_release;
    logic max_release;
    logic busy;
  } key_evt_t;

endpackage
`default_nettype wire

// ===== rtl/core/key_debounce_click_long_press_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_click_long_press_top
// Debounces up to NUM_KEYS keys in parallel and reports press, release,
// single, double, long-press, long-release and max-click-release pulses.
//
//   channel   signals                         word
//   input     in_valid / in_stall             key_levels (one scan tick)
//   output    out_valid / out_stall           seven event masks and busy_res
//   config    cfg_wr_en, cfg_index, cfg_data  one register write
//
// A tick is held in the input register; when it advances, the key logic updates
// the key state and loads the result register with the tick's events.
// One tick per cycle is sustained unless the result stalls; the key logic
// works on all keys at once. Reset clears the key state, loads the debounce
// count's reset value and the configuration defaults. A stalled result holds
// the key logic; the input register then fills and in_stall rises.
// ----------------------------------------------------------------------------
module key_debounce_click_long_press_top #(
  parameter int NUM_KEYS         = kdclp_pkg::NUM_KEYS_DEF,
  parameter int TICK_COUNT_WIDTH = kdclp_pkg::TICK_CNT_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [kdclp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kdclp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [kdclp_pkg::KEY_PORT_W-1:0]  key_levels,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  press_events,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  release_events,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  short_click_events,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  double_click_events,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  long_press_events,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  long_release_events,
  output      logic [kdclp_pkg::KEY_PORT_W-1:0]  max_click_release_events,
  output      logic                              busy_res
);

  localparam int PW = kdclp_pkg::KEY_PORT_W;

  kdclp_pkg::cfg_t     cfg;
  kdclp_pkg::key_evt_t evt [NUM_KEYS];

  logic          in_full;
  logic [PW-1:0] in_levels;
  logic          advance;

  logic [PW-1:0] press_m, rel_m, short_m, dbl_m, lpress_m, lrel_m, maxrel_m;
  logic          busy_any;

  // Configuration registers.
  kdclp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: a tick moves on when the result register is free or drains.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_levels <= key_levels;
    end
  end

  // One logic slice per key; keys past the input width see level 0.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic pin;
    if (k < PW) begin : g_pin
      assign pin = in_levels[k];
    end else begin : g_zero
      assign pin = 1'b0;
    end

    kdclp_key #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_key (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .pin (pin),
      .cfg (cfg),
      .evt (evt[k])
    );
  end

  // Gather the per-key pulses into the output masks.
  always_comb begin
    press_m  = '0;
    rel_m    = '0;
    short_m  = '0;
    dbl_m    = '0;
    lpress_m = '0;
    lrel_m   = '0;
    maxrel_m = '0;
    busy_any = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (k < PW) begin
        press_m[k]  = evt[k].press;
        rel_m[k]    = evt[k].release_ev;
        short_m[k]  = evt[k].short_click;
        dbl_m[k]    = evt[k].dbl_click;
        lpress_m[k] = evt[k].long_press;
        lrel_m[k]   = evt[k].long_release;
        maxrel_m[k] = evt[k].max_release;
      end
      busy_any = busy_any | evt[k].busy;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_events             <= press_m;
      release_events           <= rel_m;
      short_click_events       <= short_m;
      double_click_events      <= dbl_m;
      long_press_events        <= lpress_m;
      long_release_events      <= lrel_m;
      max_click_release_events <= maxrel_m;
      busy_res                 <= busy_any;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kdclp_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdclp_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module kdclp_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [kdclp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kdclp_pkg::CFG_DATA_W-1:0] cfg_data,
  output kdclp_pkg::cfg_t                       cfg
);

  // Decode the index; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= kdclp_pkg::DEBOUNCE_RESET;
      cfg.long_press_ticks <= kdclp_pkg::LONG_PRESS_RESET;
      cfg.click_gap_ticks  <= kdclp_pkg::CLICK_GAP_RESET;
      cfg.max_clicks       <= kdclp_pkg::MAX_CLICKS_RESET;
      cfg.active_low       <= 1'b1;
      cfg.long_enable      <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kdclp_pkg::REG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= cfg_data;
        kdclp_pkg::REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data;
        kdclp_pkg::REG_CLICK_GAP_TICKS:  cfg.click_gap_ticks  <= cfg_data;
        kdclp_pkg::REG_MAX_CLICKS:
          cfg.max_clicks <= cfg_data[kdclp_pkg::CLICK_W-1:0];
        kdclp_pkg::REG_ACTIVE_LOW:       cfg.active_low       <= cfg_data[0];
        kdclp_pkg::REG_LONG_ENABLE:      cfg.long_enable      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kdclp_key.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdclp_key
// State and next-state logic of one key: debounce, click count, long-press
// and inter-click gap timers.
// ----------------------------------------------------------------------------
module kdclp_key #(
  parameter int TICK_COUNT_WIDTH = kdclp_pkg::TICK_CNT_W_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            pin,
  input  wire kdclp_pkg::cfg_t cfg,
  output kdclp_pkg::key_evt_t  evt
);

  localparam int W  = TICK_COUNT_WIDTH;
  // Compare width covers both the counter and the 16-bit register value.
  localparam int CW = (W > kdclp_pkg::CFG_TICK_W) ? W : kdclp_pkg::CFG_TICK_W;
  localparam logic [kdclp_pkg::CLICK_W-1:0] ONE_CLICK = 3'd1;
  localparam logic [kdclp_pkg::CLICK_W-1:0] TWO_CLICK = 3'd2;

  // Key state registers.
  logic                          raw_last, stable_level, first_seen;
  logic [W-1:0]                  debounce_count, long_count, gap_count;
  logic [kdclp_pkg::CLICK_W-1:0] click_count;
  logic                          long_timing, gap_timing;

  logic                          raw_last_next, stable_level_next, first_seen_next;
  logic [W-1:0]                  debounce_count_next, long_count_next, gap_count_next;
  logic [kdclp_pkg::CLICK_W-1:0] click_count_next;
  logic                          long_timing_next, gap_timing_next;

  // One tick of the key: debounce and edge handling first, then timers.
  always_comb begin
    logic cur;
    logic long_hit;
    cur      = pin ^ cfg.active_low;
    long_hit = 1'b0;

    raw_last_next       = raw_last;
    stable_level_next   = stable_level;
    first_seen_next     = first_seen;
    debounce_count_next = debounce_count;
    click_count_next    = click_count;
    long_timing_next    = long_timing;
    long_count_next     = long_count;
    gap_timing_next     = gap_timing;
    gap_count_next      = gap_count;
    evt                 = '0;

    // Any raw change restarts the debounce count.
    if (raw_last != cur) begin
      raw_last_next       = cur;
      debounce_count_next = W'(cfg.debounce_ticks);
    end

    if (debounce_count_next != '0) begin
      debounce_count_next = debounce_count_next - W'(1);
      if (debounce_count_next == '0) begin
        if ((cur != stable_level) || !first_seen) begin
          first_seen_next = 1'b1;
          if (cur) begin
            // Stable press.
            evt.press       = 1'b1;
            gap_timing_next = 1'b0;
            gap_count_next  = '0;
            if (click_count_next != kdclp_pkg::CLICK_SAT) begin
              click_count_next = click_count_next + ONE_CLICK;
            end
            if (click_count_next == ONE_CLICK) begin
              if (cfg.long_enable) begin
                long_timing_next = 1'b1;
                long_count_next  = '0;
              end
            end else if (click_count_next == cfg.max_clicks) begin
              if (click_count_next == TWO_CLICK) evt.dbl_click = 1'b1;
            end
          end else begin
            // Stable release.
            evt.release_ev = 1'b1;
            long_hit = cfg.long_enable &&
                       (CW'(long_count_next) >= CW'(cfg.long_press_ticks));
            if (cfg.max_clicks == ONE_CLICK) begin
              if (click_count_next == ONE_CLICK) begin
                if (long_hit) evt.long_release = 1'b1;
                else          evt.short_click  = 1'b1;
                click_count_next = '0;
                long_timing_next = 1'b0;
                gap_timing_next  = 1'b0;
                gap_count_next   = '0;
                long_count_next  = '0;
              end
            end else if (click_count_next == ONE_CLICK) begin
              if (cfg.long_enable) long_timing_next = 1'b0;
              if (long_hit) begin
                evt.long_release = 1'b1;
                click_count_next = '0;
                long_timing_next = 1'b0;
                gap_timing_next  = 1'b0;
                gap_count_next   = '0;
                long_count_next  = '0;
              end else begin
                gap_timing_next = 1'b1;
                gap_count_next  = '0;
              end
            end else if (click_count_next != cfg.max_clicks) begin
              gap_timing_next = 1'b1;
              gap_count_next  = '0;
            end else begin
              evt.max_release  = 1'b1;
              click_count_next = '0;
              long_timing_next = 1'b0;
              gap_timing_next  = 1'b0;
              gap_count_next   = '0;
              long_count_next  = '0;
            end
          end
        end
        stable_level_next = cur;
      end
    end

    // Long-press timer runs only while the first press is held.
    if (cfg.long_enable && (click_count_next == ONE_CLICK) && long_timing_next) begin
      long_count_next = long_count_next + W'(1);
      if (CW'(long_count_next) >= CW'(cfg.long_press_ticks)) begin
        long_timing_next = 1'b0;
        long_count_next  = W'(cfg.long_press_ticks);
        evt.long_press   = 1'b1;
      end
    end

    // Gap timer closes the click sequence on expiry.
    if (gap_timing_next) begin
      gap_count_next = gap_count_next + W'(1);
      if (CW'(gap_count_next) >= CW'(cfg.click_gap_ticks)) begin
        if (click_count_next == ONE_CLICK)      evt.short_click = 1'b1;
        else if (click_count_next == TWO_CLICK) evt.dbl_click   = 1'b1;
        click_count_next = '0;
        long_timing_next = 1'b0;
        gap_timing_next  = 1'b0;
        gap_count_next   = '0;
        long_count_next  = '0;
      end
    end

    evt.busy = (debounce_count_next != '0) || long_timing_next || gap_timing_next;
  end

  // State update on each processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last       <= 1'b0;
      stable_level   <= 1'b0;
      first_seen     <= 1'b0;
      debounce_count <= W'(kdclp_pkg::DEBOUNCE_RESET);
      click_count    <= '0;
      long_timing    <= 1'b0;
      long_count     <= '0;
      gap_timing     <= 1'b0;
      gap_count      <= '0;
    end else if (en) begin
      raw_last       <= raw_last_next;
      stable_level   <= stable_level_next;
      first_seen     <= first_seen_next;
      debounce_count <= debounce_count_next;
      click_count    <= click_count_next;
      long_timing    <= long_timing_next;
      long_count     <= long_count_next;
      gap_timing     <= gap_timing_next;
      gap_count      <= gap_count_next;
    end
  end

endmodule
`default_nettype wire
